/* hw/rtl/bqc_pkg.sv */
// shared constants, types and helpers for the biquad cascade filter
package bqc_pkg;

  localparam int MAX_STAGES_DEFAULT   = 8;
  localparam int SAMPLE_WIDTH_DEFAULT = 24;
  localparam int COEF_WIDTH_DEFAULT   = 32;

  // accumulator width, wraps modulo 2^64
  localparam int ACC_WIDTH = 64;

  localparam int CFG_INDEX_WIDTH   = 3;
  localparam int STAGE_COUNT_WIDTH = 4;
  localparam int STAGE_NUM_WIDTH   = STAGE_COUNT_WIDTH + 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_B0     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_B1     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_B2     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_A1     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_A2     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STAGE_COUNT = 3'd5;

  // product steps of one section, in issue order
  localparam int STEP_WIDTH = 3;
  localparam logic [STEP_WIDTH-1:0] STEP_B0 = 3'd0;
  localparam logic [STEP_WIDTH-1:0] STEP_B1 = 3'd1;
  localparam logic [STEP_WIDTH-1:0] STEP_B2 = 3'd2;
  localparam logic [STEP_WIDTH-1:0] STEP_A1 = 3'd3;
  localparam logic [STEP_WIDTH-1:0] STEP_A2 = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FINAL,
    ST_DONE
  } state_t;

  // number of sections actually run for a stage_count value
  function automatic logic [STAGE_NUM_WIDTH-1:0] active_stages(
    input logic [STAGE_COUNT_WIDTH-1:0] count,
    input int unsigned                  max_stages
  );
    logic [STAGE_NUM_WIDTH-1:0] n;
    n = {1'b0, count};
    if (count == '0) begin
      n = STAGE_NUM_WIDTH'(1);
    end else if (32'(count) > max_stages) begin
      n = STAGE_NUM_WIDTH'(max_stages);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/biquad_cascade_filter.sv */
// cascade of direct form I biquad sections on one shared multiply-accumulate unit
//
// Each input word is run through the active sections in order, section 0 first,
// all sections sharing b0, b1, b2, a1 and a2 (Q4.28 at default width) and each
// keeping its own two past inputs and outputs. A single multiplier produces the
// five products of a section one per cycle into a 64-bit accumulator that starts
// at the rounding offset; a final step adds the last product, shifts, saturates
// and writes back the section history. The input stalls until the last section
// is done and its result is moved into the output register, so a new word is only
// taken once the previous one is through. The result sits in an output register,
// so the next word is taken while it waits. Writing stage_count clears the history
// of every section at or above the new count; writes are taken only while the
// filter is idle.
module biquad_cascade_filter #(
  parameter int MAX_STAGES   = bqc_pkg::MAX_STAGES_DEFAULT,
  parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEFAULT,
  parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bqc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0]                cfg_data
);

  import bqc_pkg::*;

  localparam int FRAC    = COEF_WIDTH - 4;
  localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SEC_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  localparam logic signed [ACC_WIDTH-1:0]  ROUND_CONST = ACC_WIDTH'(1) << (FRAC - 1);
  localparam logic [COEF_WIDTH-1:0]        ONE_COEF    = COEF_WIDTH'(1) << FRAC;

  // configuration
  logic signed [COEF_WIDTH-1:0]    coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [STAGE_COUNT_WIDTH-1:0]    stage_count;
  logic [STAGE_NUM_WIDTH-1:0]      num_stages;
  logic [STAGE_NUM_WIDTH-1:0]      new_stages;
  logic                            cfg_write;

  // per-section history
  logic signed [SAMPLE_WIDTH-1:0]  hist_x1 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0]  hist_x2 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0]  hist_y1 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0]  hist_y2 [MAX_STAGES];

  // sequencer
  state_t                          state, state_next;
  logic [STEP_WIDTH-1:0]           step, step_next;
  logic [SEC_W-1:0]                sec, sec_next;
  logic                            last_sec;
  logic                            out_free;
  logic                            in_take;
  logic                            out_load;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0]  x_cur;
  logic signed [SAMPLE_WIDTH-1:0]  mul_samp;
  logic signed [COEF_WIDTH-1:0]    mul_coef;
  logic signed [PROD_W-1:0]        prod_w;
  logic signed [ACC_WIDTH-1:0]     prod;
  logic                            prod_sub;
  logic signed [ACC_WIDTH-1:0]     acc;
  logic signed [ACC_WIDTH-1:0]     acc_sum;
  logic signed [ACC_WIDTH-1:0]     shifted;
  logic [ACC_WIDTH-SAMPLE_WIDTH:0] upper;
  logic signed [SAMPLE_WIDTH-1:0]  y_sat;

  assign cfg_ready  = (state == ST_IDLE);
  assign cfg_write  = cfg_valid && cfg_ready;
  assign num_stages = active_stages(stage_count, MAX_STAGES);
  assign new_stages = active_stages(cfg_data[STAGE_COUNT_WIDTH-1:0], MAX_STAGES);

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_sec = (STAGE_NUM_WIDTH'(sec) == (num_stages - STAGE_NUM_WIDTH'(1)));

  // operand select for the shared multiplier
  always_comb begin
    mul_samp = x_cur;
    mul_coef = coef_b0;
    case (step)
      STEP_B0: begin
        mul_samp = x_cur;
        mul_coef = coef_b0;
      end
      STEP_B1: begin
        mul_samp = hist_x1[sec];
        mul_coef = coef_b1;
      end
      STEP_B2: begin
        mul_samp = hist_x2[sec];
        mul_coef = coef_b2;
      end
      STEP_A1: begin
        mul_samp = hist_y1[sec];
        mul_coef = coef_a1;
      end
      STEP_A2: begin
        mul_samp = hist_y2[sec];
        mul_coef = coef_a2;
      end
      default: begin
        mul_samp = x_cur;
        mul_coef = coef_b0;
      end
    endcase
  end

  assign prod_w  = mul_samp * mul_coef;
  assign acc_sum = prod_sub ? (acc - prod) : (acc + prod);
  assign shifted = acc_sum >>> FRAC;
  assign upper   = shifted[ACC_WIDTH-1:SAMPLE_WIDTH-1];

  // saturate when the bits above the sample do not all match its sign
  always_comb begin
    if ((&upper) || !(|upper)) begin
      y_sat = shifted[SAMPLE_WIDTH-1:0];
    end else if (shifted[ACC_WIDTH-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_B0;
      sec   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      sec   <= sec_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    sec_next   = sec;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_MAC;
          step_next  = STEP_B0;
          sec_next   = '0;
        end
      end
      ST_MAC: begin
        if (step == STEP_A2) begin
          state_next = ST_FINAL;
        end else begin
          step_next = step + STEP_WIDTH'(1);
        end
      end
      ST_FINAL: begin
        step_next = STEP_B0;
        if (last_sec) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MAC;
          sec_next   = sec + SEC_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_cur <= sample_in;
    end else if (state == ST_FINAL) begin
      x_cur <= y_sat;
    end
    if (state == ST_MAC) begin
      prod     <= ACC_WIDTH'(prod_w);
      prod_sub <= (step == STEP_A1) || (step == STEP_A2);
      if (step == STEP_B0) begin
        acc <= ROUND_CONST;
      end else begin
        acc <= acc_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= x_cur;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0     <= ONE_COEF;
      coef_b1     <= '0;
      coef_b2     <= '0;
      coef_a1     <= '0;
      coef_a2     <= '0;
      stage_count <= STAGE_COUNT_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COEF_B0:     coef_b0 <= cfg_data;
        CFG_COEF_B1:     coef_b1 <= cfg_data;
        CFG_COEF_B2:     coef_b2 <= cfg_data;
        CFG_COEF_A1:     coef_a1 <= cfg_data;
        CFG_COEF_A2:     coef_a2 <= cfg_data;
        CFG_STAGE_COUNT: stage_count <= cfg_data[STAGE_COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // section history: writeback after each section, cleared above a new count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MAX_STAGES; s++) begin
        hist_x1[s] <= '0;
        hist_x2[s] <= '0;
        hist_y1[s] <= '0;
        hist_y2[s] <= '0;
      end
    end else if (cfg_write && (cfg_index == CFG_STAGE_COUNT)) begin
      for (int s = 0; s < MAX_STAGES; s++) begin
        if (s >= int'(new_stages)) begin
          hist_x1[s] <= '0;
          hist_x2[s] <= '0;
          hist_y1[s] <= '0;
          hist_y2[s] <= '0;
        end
      end
    end else if (state == ST_FINAL) begin
      hist_x2[sec] <= hist_x1[sec];
      hist_x1[sec] <= x_cur;
      hist_y2[sec] <= hist_y1[sec];
      hist_y1[sec] <= y_sat;
    end
  end

endmodule

/* sim/tb.sv */
// testbench for the biquad cascade filter: directed and random traffic checked against a built-in predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqc_pkg::*;

  localparam int SECTIONS = MAX_STAGES_DEFAULT;
  localparam int SW       = SAMPLE_WIDTH_DEFAULT;
  localparam int CW       = COEF_WIDTH_DEFAULT;
  localparam int FRAC     = CW - 4;

  localparam longint SAMPLE_TOP    = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;
  localparam longint ROUND_HALF    = longint'(1) << (FRAC - 1);

  localparam logic signed [SW-1:0] SMP_MAX = SW'(SAMPLE_TOP);
  localparam logic signed [SW-1:0] SMP_MIN = SW'(SAMPLE_BOTTOM);

  localparam logic [CW-1:0] COEF_MAX     = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN     = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_ONE     = CW'(longint'(1) << FRAC);
  localparam logic [CW-1:0] COEF_NEG_ONE = -COEF_ONE;
  localparam logic [CW-1:0] COEF_HALF    = COEF_ONE >> 1;
  localparam logic [CW-1:0] COEF_QUARTER = COEF_ONE >> 2;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS   = 530;
  localparam int QUIET_TAIL     = 60;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 64;

  class biquad_scoreboard;
    longint b0, b1, b2, a1, a2;
    logic [STAGE_COUNT_WIDTH-1:0] stage_cnt;
    longint x_one [SECTIONS];
    longint x_two [SECTIONS];
    longint y_one [SECTIONS];
    longint y_two [SECTIONS];
    logic signed [SW-1:0] filtered_q [$];
    int errors;

    function new();
      b0 = longint'($signed(COEF_ONE));
      b1 = 0;
      b2 = 0;
      a1 = 0;
      a2 = 0;
      stage_cnt = 1;
      errors = 0;
      for (int s = 0; s < SECTIONS; s++) begin
        x_one[s] = 0;
        x_two[s] = 0;
        y_one[s] = 0;
        y_two[s] = 0;
      end
    endfunction

    // zero count runs one section, counts past the maximum run all of them
    function int sections_in_use();
      if (stage_cnt == 0) return 1;
      if (int'(stage_cnt) > SECTIONS) return SECTIONS;
      return int'(stage_cnt);
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] data);
      case (idx)
        CFG_COEF_B0: b0 = longint'($signed(data));
        CFG_COEF_B1: b1 = longint'($signed(data));
        CFG_COEF_B2: b2 = longint'($signed(data));
        CFG_COEF_A1: a1 = longint'($signed(data));
        CFG_COEF_A2: a2 = longint'($signed(data));
        CFG_STAGE_COUNT: begin
          stage_cnt = data[STAGE_COUNT_WIDTH-1:0];
          // sections at or past the new count lose their history
          for (int s = sections_in_use(); s < SECTIONS; s++) begin
            x_one[s] = 0;
            x_two[s] = 0;
            y_one[s] = 0;
            y_two[s] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [SW-1:0] sample);
      longint x;
      longint acc;
      int n;
      x = sample;
      n = sections_in_use();
      for (int s = 0; s < n; s++) begin
        acc = b0 * x + b1 * x_one[s] + b2 * x_two[s] - a1 * y_one[s] - a2 * y_two[s]
              + ROUND_HALF;
        acc = acc >>> FRAC;
        if (acc > SAMPLE_TOP) acc = SAMPLE_TOP;
        else if (acc < SAMPLE_BOTTOM) acc = SAMPLE_BOTTOM;
        y_two[s] = y_one[s];
        y_one[s] = acc;
        x_two[s] = x_one[s];
        x_one[s] = x;
        x = acc;
      end
      filtered_q.push_back(SW'(x));
    endfunction

    function void check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (filtered_q.size() == 0) begin
        $error("sample_out: expected none, got %0d", got);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SW-1:0]       sample_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b1;
  logic signed [SW-1:0]       sample_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CW-1:0]              cfg_data  = '0;

  biquad_scoreboard sb;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int stuck_cycles = 0;

  always #6 clk = ~clk;

  biquad_cascade_filter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(sample_in);
      if (out_valid && !out_stall) sb.check_result(sample_out);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // output side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] word);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // caller lowers cfg_valid once its writes are done
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain_filter();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int sent;
    int burst;
    bit first_phase;
    logic signed [SW-1:0] word;
    logic [CW-1:0] data;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unity gain, one section
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample(-1);
    send_sample(1);
    send_sample(24'sh555555);

    // largest gains with every section on, saturating both ways
    drain_filter();
    write_reg(CFG_COEF_B0, COEF_MAX);
    write_reg(CFG_COEF_B1, COEF_MAX);
    write_reg(CFG_COEF_B2, COEF_MAX);
    write_reg(CFG_COEF_A1, COEF_MIN);
    write_reg(CFG_COEF_A2, COEF_MIN);
    write_reg(CFG_STAGE_COUNT, CW'(SECTIONS));
    cfg_valid <= 1'b0;
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample('0);

    // most negative coefficients, zero count acts as one section
    drain_filter();
    write_reg(CFG_COEF_B0, COEF_MIN);
    write_reg(CFG_COEF_B1, COEF_MIN);
    write_reg(CFG_COEF_B2, COEF_MIN);
    write_reg(CFG_COEF_A1, COEF_MIN);
    write_reg(CFG_COEF_A2, COEF_MIN);
    write_reg(CFG_STAGE_COUNT, '0);
    cfg_valid <= 1'b0;
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample(-1);

    // count above the maximum, ordinary coefficients
    drain_filter();
    write_reg(CFG_COEF_B0, COEF_ONE);
    write_reg(CFG_COEF_B1, COEF_HALF);
    write_reg(CFG_COEF_B2, -COEF_QUARTER);
    write_reg(CFG_COEF_A1, -COEF_HALF);
    write_reg(CFG_COEF_A2, COEF_QUARTER);
    write_reg(CFG_STAGE_COUNT, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_sample(24'sd1000);
    send_sample(-24'sd1000);
    send_sample(SMP_MAX);

    // dropped writes, then shrink and regrow so upper sections restart from zero
    drain_filter();
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    write_reg(CFG_STAGE_COUNT, CW'(3));
    write_reg(CFG_STAGE_COUNT, CW'(SECTIONS));
    cfg_valid <= 1'b0;
    send_sample(SMP_MAX);
    send_sample(24'sd12345);
    send_sample(SMP_MIN);

    sent = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      drain_filter();
      for (int r = 0; r <= int'(CFG_STAGE_COUNT); r++) begin
        if ($urandom_range(0, 2) != 0) begin
          if (CFG_INDEX_WIDTH'(r) == CFG_STAGE_COUNT) begin
            data = $urandom();
            data[STAGE_COUNT_WIDTH-1:0] = ($urandom_range(0, 3) == 0) ?
                STAGE_COUNT_WIDTH'($urandom_range(0, 15)) :
                STAGE_COUNT_WIDTH'($urandom_range(1, SECTIONS));
          end else begin
            case ($urandom_range(0, 5))
              0: data = $urandom();
              1: begin
                case ($urandom_range(0, 3))
                  0: data = COEF_MAX;
                  1: data = COEF_MIN;
                  2: data = COEF_ONE;
                  default: data = COEF_NEG_ONE;
                endcase
              end
              // within +-0.5, keeps the sections stable
              default: data = CW'(int'($urandom_range(0, 1 << FRAC)) - (1 << (FRAC - 1)));
            endcase
          end
          write_reg(CFG_INDEX_WIDTH'(r), data);
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
      end
      cfg_valid <= 1'b0;
      if (first_phase) hold_req = 1'b1;
      first_phase = 1'b0;

      burst = $urandom_range(15, 50);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
        case ($urandom_range(0, 9))
          0: word = SMP_MAX;
          1: word = SMP_MIN;
          2: word = SW'(int'($urandom_range(0, 512)) - 256);
          default: word = SW'($urandom());
        endcase
        send_sample(word);
        sent++;
      end
    end

    drain_filter();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
